[src/vpa_pkg.sv]
`timescale 1ns / 1ps

package vpa_pkg;

    localparam int MEM_SIZE  = 1024;
    localparam int MAX_PARTS = 32;
    localparam int IDX_W     = $clog2(MAX_PARTS);
    localparam int CNT_W     = $clog2(MAX_PARTS + 1);
    localparam int ADDR_W    = 10;
    localparam int SIZE_W    = 11;
    localparam int JOB_W     = 8;

    // Placement rules.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_NEXT  = 2'd1;
    localparam logic [1:0] FIT_BEST  = 2'd2;
    localparam logic [1:0] FIT_WORST = 2'd3;

    // Request kinds.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NO_JOB   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // One partition table entry.
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              used;
        logic [JOB_W-1:0]  owner;
    } entry_t;

endpackage

[src/vpa_table.sv]
`timescale 1ns / 1ps

// Partition table memory: one write port and one registered read port.
module vpa_table
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [vpa_pkg::IDX_W-1:0] waddr,
    input  vpa_pkg::entry_t         wdata,
    input  logic [vpa_pkg::IDX_W-1:0] raddr,
    output vpa_pkg::entry_t         rdata
);

    vpa_pkg::entry_t mem [vpa_pkg::MAX_PARTS];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/variable_partition_allocator_unit.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Content
// s_axis   | in        | tdata: op, job_id, req_size (20 bits in 24)
// m_axis   | out       | tdata: status, start_addr (12 bits in 16)
// cfg      | in        | fit_policy write, no read-back
//
// A request walks the table through one shared compare unit, one entry at a
// time (read, then check), then shifts entries for a split or a merge, each
// moved entry read and then written, and writes the changed entry back last.
// A zero-size allocate skips the walk; otherwise the single read port of the
// table sets how long a request takes.
// Reset builds entry 0; the result waits in an output register and
// no request is taken until it goes.
module variable_partition_allocator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // op[0], job_id[8:1], req_size[19:9]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status[1:0], start_addr[11:2]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);

    localparam int IW = vpa_pkg::IDX_W;
    localparam int CW = vpa_pkg::CNT_W;
    localparam int SW = vpa_pkg::SIZE_W;
    localparam int AW = vpa_pkg::ADDR_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SRD, S_SCHK, S_DEC, S_SHRD, S_SHWR,
        S_SPLIT, S_MRD, S_MCHK, S_DRD, S_DWR, S_MDONE, S_WBK, S_OUT
    } state_t;

    state_t            state_reg;
    logic [1:0]        policy_reg;
    logic              op_reg;
    logic [7:0]        job_reg;
    logic [SW-1:0]     req_reg;
    logic [CW-1:0]     count_reg;
    logic [IW-1:0]     rover_reg;
    logic [IW-1:0]     idx_reg;
    logic [CW-1:0]     n_reg;
    logic              found_reg;
    logic [IW-1:0]     best_reg;
    logic [SW-1:0]     bsize_reg;
    vpa_pkg::entry_t   bent_reg;
    logic [IW-1:0]     j_reg;
    logic [IW-1:0]     drop_reg;
    logic              mphase_reg;
    logic [1:0]        st_reg;
    logic [AW-1:0]     addr_reg;
    logic              ovalid_reg;

    logic                we;
    logic [IW-1:0]       waddr;
    vpa_pkg::entry_t     wdata;
    logic [IW-1:0]       raddr;
    vpa_pkg::entry_t     rdata;

    vpa_table u_table (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                       .raddr(raddr), .rdata(rdata));

    logic [IW-1:0] last_idx;
    logic          fit;
    logic          better;
    logic [IW-1:0] idx_wrap;
    logic [IW-1:0] rover_eff;

    // Shared compare unit and index helpers.
    always_comb
    begin
        last_idx  = IW'(count_reg - CW'(1));
        idx_wrap  = (idx_reg == last_idx) ? '0 : idx_reg + IW'(1);
        rover_eff = (CW'(rover_reg) < count_reg) ? rover_reg : '0;
        if (op_reg == vpa_pkg::OP_ALLOC)
        begin
            fit = !rdata.used && (rdata.size >= req_reg);
        end
        else
        begin
            fit = rdata.used && (rdata.owner == job_reg);
        end
        case (policy_reg)
            vpa_pkg::FIT_BEST:  better = rdata.size < bsize_reg;
            vpa_pkg::FIT_WORST: better = rdata.size > bsize_reg;
            default:            better = 1'b0;
        endcase
    end

    // Table write and read address selection.
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = bent_reg;
        raddr = idx_reg;
        case (state_reg)
            S_INIT:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{start: '0, size: SW'(vpa_pkg::MEM_SIZE), used: 1'b0, owner: '0};
            end
            S_SHRD:  raddr = j_reg - IW'(1);
            S_SHWR:
            begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = rdata;
            end
            S_SPLIT:
            begin
                we    = 1'b1;
                waddr = best_reg + IW'(1);
                wdata = '{start: bent_reg.start + AW'(req_reg),
                          size: bsize_reg - req_reg, used: 1'b0, owner: '0};
            end
            S_DRD:   raddr = j_reg + IW'(1);
            S_DWR:
            begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = rdata;
            end
            S_WBK:
            begin
                we    = 1'b1;
                waddr = best_reg;
                wdata = bent_reg;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'd0, addr_reg, st_reg};

    // Sequencer: scan, decide, shift and merge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            policy_reg <= vpa_pkg::FIT_FIRST;
            count_reg  <= CW'(1);
            rover_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT: state_reg <= S_IDLE;
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_reg    <= s_axis_tdata[0];
                        job_reg   <= s_axis_tdata[8:1];
                        req_reg   <= s_axis_tdata[19:9];
                        found_reg <= 1'b0;
                        n_reg     <= '0;
                        addr_reg  <= '0;
                        if (s_axis_tdata[0] == vpa_pkg::OP_ALLOC
                            && s_axis_tdata[19:9] == '0)
                        begin
                            st_reg    <= vpa_pkg::ST_NO_SPACE;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            if (s_axis_tdata[0] == vpa_pkg::OP_ALLOC
                                && policy_reg == vpa_pkg::FIT_NEXT)
                            begin
                                idx_reg <= (CW'(rover_reg) < count_reg) ? rover_reg : '0;
                            end
                            else
                            begin
                                idx_reg <= '0;
                            end
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_SRD: state_reg <= S_SCHK;
                S_SCHK:
                begin
                    // Candidate update from the shared compare.
                    if (fit && (!found_reg || better))
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= idx_reg;
                        bsize_reg <= rdata.size;
                        bent_reg  <= rdata;
                    end
                    n_reg <= n_reg + CW'(1);
                    if ((fit && (op_reg == vpa_pkg::OP_FREE
                                 || policy_reg == vpa_pkg::FIT_FIRST
                                 || policy_reg == vpa_pkg::FIT_NEXT))
                        || (n_reg + CW'(1) == count_reg))
                    begin
                        state_reg <= S_DEC;
                    end
                    else
                    begin
                        idx_reg   <= (op_reg == vpa_pkg::OP_ALLOC
                                      && policy_reg == vpa_pkg::FIT_NEXT) ? idx_wrap
                                                                      : idx_reg + IW'(1);
                        state_reg <= S_SRD;
                    end
                end
                S_DEC:
                begin
                    // The chosen entry is updated here and written back at the end.
                    if (!found_reg)
                    begin
                        state_reg <= S_OUT;
                        if (op_reg == vpa_pkg::OP_FREE)
                        begin
                            st_reg <= vpa_pkg::ST_NO_JOB;
                        end
                        else
                        begin
                            st_reg <= vpa_pkg::ST_NO_SPACE;
                            if (policy_reg == vpa_pkg::FIT_NEXT)
                            begin
                                rover_reg <= (rover_eff == last_idx) ? '0
                                                                     : rover_eff + IW'(1);
                            end
                        end
                    end
                    else if (op_reg == vpa_pkg::OP_ALLOC && bent_reg.size != req_reg
                             && count_reg == CW'(vpa_pkg::MAX_PARTS))
                    begin
                        st_reg    <= vpa_pkg::ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else if (op_reg == vpa_pkg::OP_ALLOC)
                    begin
                        st_reg         <= vpa_pkg::ST_DONE;
                        addr_reg       <= bent_reg.start;
                        bent_reg.size  <= req_reg;
                        bent_reg.used  <= 1'b1;
                        bent_reg.owner <= job_reg;
                        if (bent_reg.size != req_reg)
                        begin
                            if (rover_reg > best_reg)
                            begin
                                rover_reg <= rover_reg + IW'(1);
                            end
                            j_reg     <= IW'(count_reg);
                            state_reg <= (IW'(count_reg) > best_reg + IW'(1)) ? S_SHRD
                                                                             : S_SPLIT;
                            count_reg <= count_reg + CW'(1);
                        end
                        else
                        begin
                            if (policy_reg == vpa_pkg::FIT_NEXT)
                            begin
                                rover_reg <= (best_reg == last_idx) ? '0 : best_reg + IW'(1);
                            end
                            state_reg <= S_WBK;
                        end
                    end
                    else
                    begin
                        st_reg         <= vpa_pkg::ST_DONE;
                        addr_reg       <= bent_reg.start;
                        bent_reg.used  <= 1'b0;
                        bent_reg.owner <= '0;
                        if (best_reg != last_idx)
                        begin
                            mphase_reg <= 1'b0;
                            idx_reg    <= best_reg + IW'(1);
                            state_reg  <= S_MRD;
                        end
                        else if (best_reg != '0)
                        begin
                            mphase_reg <= 1'b1;
                            idx_reg    <= best_reg - IW'(1);
                            state_reg  <= S_MRD;
                        end
                        else
                        begin
                            state_reg <= S_WBK;
                        end
                    end
                end
                S_SHRD: state_reg <= S_SHWR;
                S_SHWR:
                begin
                    j_reg     <= j_reg - IW'(1);
                    state_reg <= (j_reg - IW'(1) > best_reg + IW'(1)) ? S_SHRD : S_SPLIT;
                end
                S_SPLIT:
                begin
                    // The remainder always sits right after the grant.
                    if (policy_reg == vpa_pkg::FIT_NEXT)
                    begin
                        rover_reg <= best_reg + IW'(1);
                    end
                    state_reg <= S_WBK;
                end
                S_MRD: state_reg <= S_MCHK;
                S_MCHK:
                begin
                    if (!mphase_reg)
                    begin
                        // Upper neighbour.
                        if (!rdata.used)
                        begin
                            bent_reg.size <= bent_reg.size + rdata.size;
                            drop_reg      <= best_reg + IW'(1);
                            j_reg         <= best_reg + IW'(1);
                            state_reg     <= (best_reg + IW'(1) == last_idx) ? S_MDONE
                                                                             : S_DRD;
                        end
                        else if (best_reg != '0)
                        begin
                            mphase_reg <= 1'b1;
                            idx_reg    <= best_reg - IW'(1);
                            state_reg  <= S_MRD;
                        end
                        else
                        begin
                            state_reg <= S_WBK;
                        end
                    end
                    else if (!rdata.used)
                    begin
                        // Lower neighbour absorbs this entry.
                        bent_reg.size  <= bent_reg.size + rdata.size;
                        bent_reg.start <= rdata.start;
                        drop_reg       <= best_reg;
                        j_reg          <= best_reg;
                        best_reg       <= best_reg - IW'(1);
                        state_reg      <= (best_reg == last_idx) ? S_MDONE : S_DRD;
                    end
                    else
                    begin
                        state_reg <= S_WBK;
                    end
                end
                S_DRD: state_reg <= S_DWR;
                S_DWR:
                begin
                    // Entries above the dropped one move down by one.
                    if (j_reg + IW'(1) == last_idx)
                    begin
                        state_reg <= S_MDONE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_DRD;
                    end
                end
                S_MDONE:
                begin
                    // Shrink the table, keep the rover on its partition, then try below.
                    count_reg <= count_reg - CW'(1);
                    if (rover_reg >= drop_reg && rover_reg != '0)
                    begin
                        rover_reg <= rover_reg - IW'(1);
                    end
                    if (!mphase_reg && best_reg != '0)
                    begin
                        mphase_reg <= 1'b1;
                        idx_reg    <= best_reg - IW'(1);
                        state_reg  <= S_MRD;
                    end
                    else
                    begin
                        state_reg <= S_WBK;
                    end
                end
                S_WBK: state_reg <= S_OUT;
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[src/vpa_checker.sv]
`timescale 1ns / 1ps

module vpa_props
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata
);

    // A result stays offered until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // No new request while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken with result pending");

    // A failed request reports a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != vpa_pkg::ST_DONE |-> m_axis_tdata[11:2] == 10'd0)
        else $error("address on failed request");

    // A request is not answered in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");

endmodule

bind variable_partition_allocator_unit vpa_props u_vpa_props (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));

[test/vpa_checker.sv]
`timescale 1ns / 1ps

module vpa_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          grants,
    output int          refusals
);

    typedef struct packed {
        logic [1:0]                 status;
        logic [vpa_pkg::ADDR_W-1:0] addr;
    } answer_t;

    // Shadow copy of the partition table.
    int          tbl_start [vpa_pkg::MAX_PARTS];
    int          tbl_size  [vpa_pkg::MAX_PARTS];
    bit          tbl_used  [vpa_pkg::MAX_PARTS];
    int          tbl_owner [vpa_pkg::MAX_PARTS];
    int          tbl_count;
    int          rover;
    logic [1:0]  policy;
    answer_t     answers_due[$];

    function automatic int next_slot(int i);
        return (i + 1 < tbl_count) ? i + 1 : 0;
    endfunction

    // Removes entry k and keeps the rover on the same partition.
    function automatic void remove_entry(int k);
        for (int j = k; j + 1 < tbl_count; j++)
        begin
            tbl_start[j] = tbl_start[j+1];
            tbl_size[j]  = tbl_size[j+1];
            tbl_used[j]  = tbl_used[j+1];
            tbl_owner[j] = tbl_owner[j+1];
        end
        tbl_count--;
        if (rover >= k && rover > 0)
            rover--;
    endfunction

    // Chooses a free partition by the placement rule; tbl_count when none fits.
    function automatic int choose_slot(int req);
        int i;
        int found;
        found = tbl_count;
        if (policy == vpa_pkg::FIT_NEXT)
        begin
            i = (rover < tbl_count) ? rover : 0;
            for (int n = 0; n < tbl_count; n++)
            begin
                if (!tbl_used[i] && tbl_size[i] >= req)
                    return i;
                i = next_slot(i);
            end
            return tbl_count;
        end
        for (i = 0; i < tbl_count; i++)
        begin
            if (tbl_used[i] || tbl_size[i] < req)
                continue;
            if (policy == vpa_pkg::FIT_FIRST)
                return i;
            if (found == tbl_count ||
                (policy == vpa_pkg::FIT_BEST && tbl_size[i] < tbl_size[found]) ||
                (policy == vpa_pkg::FIT_WORST && tbl_size[i] > tbl_size[found]))
                found = i;
        end
        return found;
    endfunction

    function automatic answer_t grant(int job, int req);
        answer_t r;
        int i;
        r = '{vpa_pkg::ST_NO_SPACE, '0};
        if (req == 0)
            return r;
        i = choose_slot(req);
        if (i >= tbl_count)
        begin
            if (policy == vpa_pkg::FIT_NEXT)
                rover = next_slot(rover < tbl_count ? rover : 0);
            return r;
        end
        if (tbl_size[i] != req)
        begin
            if (tbl_count >= vpa_pkg::MAX_PARTS)
            begin
                r.status = vpa_pkg::ST_FULL;
                return r;
            end
            for (int j = tbl_count; j > i + 1; j--)
            begin
                tbl_start[j] = tbl_start[j-1];
                tbl_size[j]  = tbl_size[j-1];
                tbl_used[j]  = tbl_used[j-1];
                tbl_owner[j] = tbl_owner[j-1];
            end
            tbl_count++;
            if (rover > i)
                rover++;
            tbl_start[i+1] = tbl_start[i] + req;
            tbl_size[i+1]  = tbl_size[i] - req;
            tbl_used[i+1]  = 0;
            tbl_owner[i+1] = 0;
            tbl_size[i]    = req;
        end
        tbl_used[i]  = 1;
        tbl_owner[i] = job;
        r.status = vpa_pkg::ST_DONE;
        r.addr   = vpa_pkg::ADDR_W'(tbl_start[i]);
        if (policy == vpa_pkg::FIT_NEXT)
            rover = next_slot(i);
        return r;
    endfunction

    function automatic answer_t release_job(int job);
        answer_t r;
        int k;
        r = '{vpa_pkg::ST_NO_JOB, '0};
        for (k = 0; k < tbl_count; k++)
            if (tbl_used[k] && tbl_owner[k] == job)
                break;
        if (k >= tbl_count)
            return r;
        r.status = vpa_pkg::ST_DONE;
        r.addr   = vpa_pkg::ADDR_W'(tbl_start[k]);
        tbl_used[k]  = 0;
        tbl_owner[k] = 0;
        if (k + 1 < tbl_count && !tbl_used[k+1])
        begin
            tbl_size[k] += tbl_size[k+1];
            remove_entry(k + 1);
        end
        if (k > 0 && !tbl_used[k-1])
        begin
            tbl_size[k-1] += tbl_size[k];
            remove_entry(k);
        end
        return r;
    endfunction

    // Predict on each request transaction, compare on each result transaction.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_r;
        answer_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < vpa_pkg::MAX_PARTS; i++)
            begin
                tbl_start[i] = 0;
                tbl_size[i]  = 0;
                tbl_used[i]  = 0;
                tbl_owner[i] = 0;
            end
            tbl_size[0] = vpa_pkg::MEM_SIZE;
            tbl_count   = 1;
            rover       = 0;
            policy      = vpa_pkg::FIT_FIRST;
            fail_count  = 0;
            grants      = 0;
            refusals    = 0;
            answers_due.delete();
            pending     = 0;
        end
        else
        begin
            if (cfg_we)
                policy = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tdata[0] == vpa_pkg::OP_ALLOC)
                    exp_r = grant(s_axis_tdata[8:1], s_axis_tdata[19:9]);
                else
                    exp_r = release_job(s_axis_tdata[8:1]);
                if (exp_r.status == vpa_pkg::ST_DONE)
                    grants++;
                else
                    refusals++;
                answers_due.push_back(exp_r);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[1:0];
                got.addr   = m_axis_tdata[11:2];
                if (answers_due.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d addr %0d",
                             $time, got.status, got.addr);
                    fail_count++;
                end
                else
                begin
                    exp_r = answers_due.pop_front();
                    if (got.status !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.addr !== exp_r.addr)
                    begin
                        $display("%0t: start_addr expected %0d actual %0d",
                                 $time, exp_r.addr, got.addr);
                        fail_count++;
                    end
                end
            end
            pending = answers_due.size();
        end
    end

endmodule

[test/tb_variable_partition_allocator_unit.sv]
`timescale 1ns / 1ps

module tb_variable_partition_allocator_unit;

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 2000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    int          fail_count;
    int          pending;
    int          grants;
    int          refusals;
    int          cycles;
    bit          calm;
    bit          hold_off;
    int          sent;

    variable_partition_allocator_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    vpa_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .grants        (grants),
        .refusals      (refusals)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog on total run length.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off.
    initial
    begin
        int n;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_axis_tready <= 0;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 8);
                m_axis_tready <= 0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1;
                @(posedge clk);
            end
        end
    end

    // Offers one request and returns at the edge that accepts it; the valid
    // stays up so that the next request can follow without a gap.
    task automatic send(input logic op, input logic [7:0] job, input logic [10:0] sz);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {4'b0, sz, job, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic stop_input();
        s_axis_tvalid <= 0;
        @(posedge clk);
    endtask

    task automatic settle_and_set(input logic [1:0] pol);
        stop_input();
        while (pending != 0)
            @(posedge clk);
        repeat (4 * vpa_pkg::MAX_PARTS + 8) @(posedge clk);
        cfg_we    <= 1;
        cfg_wdata <= pol;
        @(posedge clk);
        cfg_we    <= 0;
    endtask

    // Random request mix: mostly allocations and frees of recently used jobs.
    task automatic random_phase(input int count);
        logic [10:0] sz;
        logic [7:0]  job;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0:       sz = 11'($urandom_range(0, 2047));
                1:       sz = 11'($urandom_range(256, 1024));
                default: sz = 11'($urandom_range(1, 64));
            endcase
            job = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            send($urandom_range(0, 9) < 5 ? vpa_pkg::OP_ALLOC : vpa_pkg::OP_FREE, job, sz);
        end
    endtask

    initial
    begin
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        cfg_we        = 0;
        cfg_wdata     = vpa_pkg::FIT_FIRST;
        calm          = 0;
        hold_off      = 0;
        sent          = 0;
        rst_n         = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: zero size, oversize, whole memory, free paths, table full.
        send(vpa_pkg::OP_ALLOC, 8'd1, 11'd0);
        send(vpa_pkg::OP_ALLOC, 8'd1, 11'd1025);
        send(vpa_pkg::OP_ALLOC, 8'd1, 11'd2047);
        send(vpa_pkg::OP_FREE,  8'd9, 11'd0);
        send(vpa_pkg::OP_ALLOC, 8'd255, 11'd1024);
        send(vpa_pkg::OP_FREE,  8'd255, 11'd0);
        for (int j = 0; j < 33; j++)
            send(vpa_pkg::OP_ALLOC, 8'(j), 11'd1);
        send(vpa_pkg::OP_FREE, 8'd0, 11'd0);
        send(vpa_pkg::OP_FREE, 8'd2, 11'd0);
        send(vpa_pkg::OP_FREE, 8'd1, 11'd0);
        send(vpa_pkg::OP_ALLOC, 8'd170, 11'd1365);

        // Sweep each placement rule with random traffic; the long stall comes first.
        for (int p = 0; p < 4; p++)
        begin
            settle_and_set(p[1:0]);
            if (p == 0)
                hold_off = 1;
            random_phase(RANDOM_ITEMS / 5);
        end
        settle_and_set(vpa_pkg::FIT_NEXT);
        calm = 1;
        random_phase(RANDOM_ITEMS / 5);

        stop_input();
        while (pending != 0)
            @(posedge clk);
        repeat (4 * vpa_pkg::MAX_PARTS + 8) @(posedge clk);
        $display("Sent %0d requests over all four placement rules: %0d granted or released,",
                 sent, grants);
        $display("%0d refused (no space, unknown job or full table).", refusals);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
src/vpa_pkg.sv
src/vpa_table.sv
src/variable_partition_allocator_unit.sv
src/vpa_checker.sv
test/vpa_checker.sv
test/tb_variable_partition_allocator_unit.sv
